// File: design/cmvm_pkg.sv
package cmvm_pkg;

    localparam int MAX_COLS   = 256;
    localparam int ADDR_W     = $clog2(MAX_COLS);
    localparam int COL_W      = ADDR_W + 1;
    localparam int ROW_W      = 16;
    localparam int DATA_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_COL_COUNT = 1'b0,
        CFG_ROW_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        op_t               op;
        logic [DATA_W-1:0] elem_real;
        logic [DATA_W-1:0] elem_imag;
        logic [ADDR_W-1:0] addr;
        logic              row_end;
        logic [ROW_W-1:0]  row_index;
        logic              last_row;
    } queue_entry_t;

endpackage

// File: design/cmvm_front.sv
module cmvm_front
    import cmvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [0:0]            op,
    input  logic [DATA_W-1:0]     elem_real,
    input  logic [DATA_W-1:0]     elem_imag,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  queue_full,
    output logic                  push,
    output queue_entry_t          push_entry
);

    logic [COL_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [ADDR_W-1:0] load_ptr_reg;
    logic [ADDR_W-1:0] col_ptr_reg;
    logic [ROW_W-1:0]  row_ctr_reg;

    logic [COL_W-1:0]  cols_eff;
    logic [ROW_W-1:0]  rows_eff;
    logic              load_wrap;
    logic              col_end;
    logic              last;
    op_t               op_in;

    assign op_in    = op_t'(op[0]);
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        priority if (col_count_reg == '0)
            cols_eff = COL_W'(1);
        else if (col_count_reg > COL_W'(MAX_COLS))
            cols_eff = COL_W'(MAX_COLS);
        else
            cols_eff = col_count_reg;
        rows_eff  = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
        load_wrap = ({1'b0, load_ptr_reg} + COL_W'(1)) >= cols_eff;
        col_end   = ({1'b0, col_ptr_reg} + COL_W'(1)) >= cols_eff;
        last      = ({1'b0, row_ctr_reg} + (ROW_W+1)'(1)) >= {1'b0, rows_eff};
    end

    always_comb
    begin
        push_entry.op        = op_in;
        push_entry.elem_real = elem_real;
        push_entry.elem_imag = elem_imag;
        push_entry.addr      = (op_in == OP_MATRIX) ? col_ptr_reg : load_ptr_reg;
        push_entry.row_end   = (op_in == OP_MATRIX) && col_end;
        push_entry.row_index = row_ctr_reg;
        push_entry.last_row  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= COL_W'(16);
            row_count_reg <= ROW_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COL_COUNT: col_count_reg <= cfg_data[COL_W-1:0];
                CFG_ROW_COUNT: row_count_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            col_ptr_reg  <= '0;
            row_ctr_reg  <= '0;
        end
        else if (push)
        begin
            if (op_in == OP_LOAD)
            begin
                load_ptr_reg <= load_wrap ? '0 : load_ptr_reg + ADDR_W'(1);
            end
            else if (col_end)
            begin
                col_ptr_reg <= '0;
                row_ctr_reg <= last ? '0 : row_ctr_reg + ROW_W'(1);
            end
            else
            begin
                col_ptr_reg <= col_ptr_reg + ADDR_W'(1);
            end
        end
    end

endmodule

// File: design/cmvm_queue.sv
module cmvm_queue
    import cmvm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output queue_entry_t pop_entry,
    output logic         empty
);

    queue_entry_t        entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full      = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (QPTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: design/cmvm_back.sv
module cmvm_back
    import cmvm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     queue_empty,
    input  queue_entry_t             pop_entry,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] res_real,
    output logic signed [DATA_W-1:0] res_imag,
    output logic [ROW_W-1:0]         row_index,
    output logic                     last_row
);

    logic [2*DATA_W-1:0] mem [MAX_COLS];

    logic                advance;

    logic                s1_valid_reg;
    logic [DATA_W-1:0]   s1_real_reg;
    logic [DATA_W-1:0]   s1_imag_reg;
    logic [2*DATA_W-1:0] s1_rd_reg;
    logic                s1_row_end_reg;
    logic [ROW_W-1:0]    s1_row_index_reg;
    logic                s1_last_reg;

    logic                s2_valid_reg;
    logic [DATA_W-1:0]   s2_rr_reg;
    logic [DATA_W-1:0]   s2_ii_reg;
    logic [DATA_W-1:0]   s2_ri_reg;
    logic [DATA_W-1:0]   s2_ir_reg;
    logic                s2_row_end_reg;
    logic [ROW_W-1:0]    s2_row_index_reg;
    logic                s2_last_reg;

    logic [DATA_W-1:0]   acc_real_reg;
    logic [DATA_W-1:0]   acc_imag_reg;
    logic [DATA_W-1:0]   acc_real_next;
    logic [DATA_W-1:0]   acc_imag_next;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   res_real_reg;
    logic [DATA_W-1:0]   res_imag_reg;
    logic [ROW_W-1:0]    row_index_reg;
    logic                last_row_reg;

    logic [DATA_W-1:0]   br;
    logic [DATA_W-1:0]   bi;
    logic [2*DATA_W-1:0] prod_rr;
    logic [2*DATA_W-1:0] prod_ii;
    logic [2*DATA_W-1:0] prod_ri;
    logic [2*DATA_W-1:0] prod_ir;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !queue_empty;

    assign br      = s1_rd_reg[DATA_W-1:0];
    assign bi      = s1_rd_reg[2*DATA_W-1:DATA_W];
    assign prod_rr = {{DATA_W{1'b0}}, s1_real_reg} * {{DATA_W{1'b0}}, br};
    assign prod_ii = {{DATA_W{1'b0}}, s1_imag_reg} * {{DATA_W{1'b0}}, bi};
    assign prod_ri = {{DATA_W{1'b0}}, s1_real_reg} * {{DATA_W{1'b0}}, bi};
    assign prod_ir = {{DATA_W{1'b0}}, s1_imag_reg} * {{DATA_W{1'b0}}, br};

    assign acc_real_next = acc_real_reg + (s2_rr_reg - s2_ii_reg);
    assign acc_imag_next = acc_imag_reg + (s2_ri_reg + s2_ir_reg);

    // vector store and registered read
    always_ff @(posedge clk)
    begin
        if (pop && pop_entry.op == OP_LOAD)
            mem[pop_entry.addr] <= {pop_entry.elem_imag, pop_entry.elem_real};
        if (pop && pop_entry.op == OP_MATRIX)
            s1_rd_reg <= mem[pop_entry.addr];
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_real_reg      <= pop_entry.elem_real;
            s1_imag_reg      <= pop_entry.elem_imag;
            s1_row_end_reg   <= pop_entry.row_end;
            s1_row_index_reg <= pop_entry.row_index;
            s1_last_reg      <= pop_entry.last_row;

            s2_rr_reg        <= prod_rr[DATA_W-1:0];
            s2_ii_reg        <= prod_ii[DATA_W-1:0];
            s2_ri_reg        <= prod_ri[DATA_W-1:0];
            s2_ir_reg        <= prod_ir[DATA_W-1:0];
            s2_row_end_reg   <= s1_row_end_reg;
            s2_row_index_reg <= s1_row_index_reg;
            s2_last_reg      <= s1_last_reg;

            if (s2_valid_reg && s2_row_end_reg)
            begin
                res_real_reg  <= acc_real_next;
                res_imag_reg  <= acc_imag_next;
                row_index_reg <= s2_row_index_reg;
                last_row_reg  <= s2_last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_real_reg  <= '0;
            acc_imag_reg  <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop && pop_entry.op == OP_MATRIX;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_row_end_reg;
            if (s2_valid_reg)
            begin
                acc_real_reg <= s2_row_end_reg ? '0 : acc_real_next;
                acc_imag_reg <= s2_row_end_reg ? '0 : acc_imag_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res_real  = res_real_reg;
    assign res_imag  = res_imag_reg;
    assign row_index = row_index_reg;
    assign last_row  = last_row_reg;

endmodule

// File: design/complex_int16_matrix_vector_multiply_core.sv
// a matrix request that closes a row passes the queue, the s1 and s2 stage registers and the result register
// throughput: one request per cycle while the queue is not full and the back pipeline is not stalled,
// set by the single vector store port and one complex multiply-accumulate per cycle in the back pipeline
// a stalled result freezes the back pipeline; the 4-entry queue keeps taking requests until full
// reset: pointers, row counter and accumulator clear, col_count and row_count return to 16
module complex_int16_matrix_vector_multiply_core
    import cmvm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [0:0]               op,
    input  logic signed [DATA_W-1:0] elem_real,
    input  logic signed [DATA_W-1:0] elem_imag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] res_real,
    output logic signed [DATA_W-1:0] res_imag,
    output logic [ROW_W-1:0]         row_index,
    output logic                     last_row,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic         push;
    queue_entry_t push_entry;
    logic         queue_full;
    logic         pop;
    queue_entry_t pop_entry;
    logic         queue_empty;

    cmvm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .elem_real  (elem_real),
        .elem_imag  (elem_imag),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cmvm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty)
    );

    cmvm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_entry   (pop_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res_real    (res_real),
        .res_imag    (res_imag),
        .row_index   (row_index),
        .last_row    (last_row)
    );

endmodule
